// File: rtl/grc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared constants, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int FB         = 16;                    // fraction bits
  localparam int MAP_W      = 16;
  localparam int MAP_H      = 16;
  localparam int MAP_DEPTH  = MAP_W * MAP_H;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);
  localparam int IDX_W      = 4;                     // bits of one cell index
  localparam int CELL_W     = 6;                     // signed walk cell index
  localparam int ORG_W      = 20;
  localparam int DIR_W      = 18;
  localparam int DIST_W     = 24;
  localparam int WC_W       = 16;
  localparam int STEP_W     = 2 * FB + 1;            // holds 2^(2F)
  localparam int SIDE_W     = 40;
  localparam int NUM_W      = 24;
  localparam int DIV_W      = NUM_W + FB;
  localparam int DVS_W      = DIR_W;
  localparam int FRAC_W     = FB + 1;                // 0 .. 2^F
  localparam int PROD_W     = 2 * FRAC_W;
  localparam int WPROD_W    = DIST_W + 1 + DIR_W;
  localparam int EPS_RAW    = ((1 << FB) + 5000) / 10000;
  localparam int EPS        = (EPS_RAW == 0) ? 1 : EPS_RAW;
  localparam int WALK_LIMIT = MAP_W + MAP_H + 2;
  localparam int CNT_W      = $clog2(WALK_LIMIT + 1);
  localparam logic [DIST_W-1:0] DIST_TOP = '1;

  // operation codes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
    ST_WALK, ST_PROBE, ST_DD_GO, ST_DD_WAIT, ST_WMUL, ST_OUT
  } state_e;

  typedef enum logic [1:0] {DIV_STEP_X, DIV_STEP_Y, DIV_DIST} div_sel_e;
  typedef enum logic [1:0] {MUL_X_HI, MUL_X_LO, MUL_Y_HI, MUL_Y_LO} mul_sel_e;
  typedef enum logic [2:0] {ACC_NONE, ACC_SET_X, ACC_ADD_X, ACC_SET_Y, ACC_ADD_Y} acc_op_e;

  typedef struct packed {
    logic     wr_cell;
    logic     load;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     step;
    logic     wall_mul;
    logic     out_en;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic hit;
    logic limit;
  } status_t;

endpackage

// File: rtl/grc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/grc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned, one quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module grc_div
  import grc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int DCNT_W = $clog2(DIV_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    shifted;
  logic              ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/grc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster datapath
// Wall map, step and side distances, DDA walk, distance and wall coordinate.
// ----------------------------------------------------------------------------
module grc_dp
  import grc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output status_t                  status_o,
  input  logic [IDX_W-1:0]         cell_x_i,
  input  logic [IDX_W-1:0]         cell_y_i,
  input  logic                     cell_is_wall_i,
  input  logic [ORG_W-1:0]         origin_x_i,
  input  logic [ORG_W-1:0]         origin_y_i,
  input  logic signed [DIR_W-1:0]  direction_x_i,
  input  logic signed [DIR_W-1:0]  direction_y_i,
  output logic                     result_valid_o,
  output logic [DIST_W-1:0]        hit_distance_o,
  output logic [WC_W-1:0]          wall_coordinate_o,
  output logic signed [CELL_W-1:0] hit_cell_x_o,
  output logic signed [CELL_W-1:0] hit_cell_y_o,
  output logic                     vertical_side_o
);

  localparam logic [FRAC_W-1:0] ONE_F     = FRAC_W'(1) << FB;
  localparam logic [STEP_W-1:0] DELTA_MAX = STEP_W'(1) << (2 * FB);

  // operands and walk state
  logic [ORG_W-1:0]         ox_q, oy_q;
  logic signed [DIR_W-1:0]  dx_q, dy_q;
  logic [FRAC_W-1:0]        fx_q, fy_q;
  logic [STEP_W-1:0]        stepx_q, stepy_q;
  logic [SIDE_W-1:0]        sidex_q, sidey_q;
  logic signed [CELL_W-1:0] cx_q, cy_q;
  logic                     vert_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DIST_W-1:0]        dist_q;
  logic signed [WPROD_W-1:0] wprod_q;
  logic                     oob_q, vld_q;
  logic [MAP_DEPTH-1:0]     valid_q;

  // result registers
  logic                     res_valid_q;
  logic [DIST_W-1:0]        res_dist_q;
  logic [WC_W-1:0]          res_wc_q;
  logic signed [CELL_W-1:0] res_cx_q, res_cy_q;
  logic                     res_vert_q;

  logic                     dxneg, dyneg;
  logic [DIR_W-1:0]         magx, magy, divx, divy;
  logic                     smallx, smally;
  logic                     div_done;
  logic [DIV_W-1:0]         quotient, div_dividend;
  logic [DVS_W-1:0]         div_divisor;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         mag_num;
  logic                     num_neg, div_neg, dist_neg;
  logic [DIST_W-1:0]        dist_calc;
  logic [FRAC_W-1:0]        mul_a, mul_b;
  logic                     lt;
  logic signed [CELL_W-1:0] nx, ny;
  logic [ADDR_W-1:0]        raddr, waddr;
  logic                     ram_rd;
  logic                     oob_next;
  logic signed [DIR_W-1:0]  comp;
  logic [ORG_W-1:0]         org_other;
  logic                     flip;
  logic [WC_W-1:0]          u_raw, u_fin;

  assign dxneg  = dx_q[DIR_W-1];
  assign dyneg  = dy_q[DIR_W-1];
  assign magx   = dxneg ? DIR_W'(-dx_q) : DIR_W'(dx_q);
  assign magy   = dyneg ? DIR_W'(-dy_q) : DIR_W'(dy_q);
  assign smallx = magx < DIR_W'(EPS);
  assign smally = magy < DIR_W'(EPS);
  assign divx   = smallx ? DIR_W'(EPS) : magx;
  assign divy   = smally ? DIR_W'(EPS) : magy;

  // numerator of the distance: offset from origin to the entered cell face
  always_comb begin
    if (vert_q) begin
      num = NUM_W'($signed({cx_q, FB'(0)})) - $signed(NUM_W'(ox_q))
          + (dxneg ? $signed(NUM_W'(ONE_F)) : $signed(NUM_W'(0)));
      div_neg = !smallx && dxneg;
    end else begin
      num = NUM_W'($signed({cy_q, FB'(0)})) - $signed(NUM_W'(oy_q))
          + (dyneg ? $signed(NUM_W'(ONE_F)) : $signed(NUM_W'(0)));
      div_neg = !smally && dyneg;
    end
    num_neg = num[NUM_W-1];
    mag_num = num_neg ? NUM_W'(-num) : NUM_W'(num);
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_STEP_X: begin
        div_dividend = DIV_W'(DELTA_MAX);
        div_divisor  = magx;
      end
      DIV_STEP_Y: begin
        div_dividend = DIV_W'(DELTA_MAX);
        div_divisor  = magy;
      end
      DIV_DIST: begin
        div_dividend = {mag_num, FB'(0)};
        div_divisor  = vert_q ? divx : divy;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // opposite signs mean the face lies behind the origin: floor at epsilon
  assign dist_neg  = num_neg != div_neg;
  assign dist_calc = (dist_neg || quotient < DIV_W'(EPS)) ? DIST_W'(EPS) :
                     (quotient > DIV_W'(DIST_TOP)) ? DIST_TOP : quotient[DIST_W-1:0];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_X_HI: begin mul_a = fx_q; mul_b = stepx_q[STEP_W-1:FB]; end
      MUL_X_LO: begin mul_a = fx_q; mul_b = {1'b0, stepx_q[FB-1:0]}; end
      MUL_Y_HI: begin mul_a = fy_q; mul_b = stepy_q[STEP_W-1:FB]; end
      MUL_Y_LO: begin mul_a = fy_q; mul_b = {1'b0, stepy_q[FB-1:0]}; end
      default:  begin mul_a = '0;   mul_b = '0; end
    endcase
  end

  // one DDA step: advance along the axis whose side distance is shorter, y on a tie
  assign lt       = sidex_q < sidey_q;
  assign nx       = lt ? cx_q + (dxneg ? -CELL_W'(1) : CELL_W'(1)) : cx_q;
  assign ny       = lt ? cy_q : cy_q + (dyneg ? -CELL_W'(1) : CELL_W'(1));
  assign oob_next = (nx[CELL_W-1:IDX_W] != '0) || (ny[CELL_W-1:IDX_W] != '0);
  assign raddr    = {ny[IDX_W-1:0], nx[IDX_W-1:0]};
  assign waddr    = {cell_y_i, cell_x_i};

  grc_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_cell),
    .waddr_i (waddr),
    .wdata_i (cell_is_wall_i),
    .raddr_i (raddr),
    .rdata_o (ram_rd)
  );

  always_comb begin
    if (vert_q) begin
      comp      = dy_q;
      org_other = oy_q;
      flip      = !dxneg && (dx_q != '0);
    end else begin
      comp      = dx_q;
      org_other = ox_q;
      flip      = dyneg;
    end
    u_raw = WC_W'(org_other[FB-1:0]) + wprod_q[2*FB-1:FB];
    if (flip) begin
      u_fin = (u_raw == '0) ? '1 : WC_W'(-u_raw);
    end else begin
      u_fin = u_raw;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.wr_cell) begin
        valid_q[waddr] <= 1'b1;
      end
      res_valid_q <= cmd_i.out_en;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q   <= origin_x_i;
      oy_q   <= origin_y_i;
      dx_q   <= direction_x_i;
      dy_q   <= direction_y_i;
      cx_q   <= CELL_W'(origin_x_i[ORG_W-1:FB]);
      cy_q   <= CELL_W'(origin_y_i[ORG_W-1:FB]);
      vert_q <= 1'b0;
      fx_q   <= direction_x_i[DIR_W-1] ? FRAC_W'(origin_x_i[FB-1:0])
                                       : ONE_F - FRAC_W'(origin_x_i[FB-1:0]);
      fy_q   <= direction_y_i[DIR_W-1] ? FRAC_W'(origin_y_i[FB-1:0])
                                       : ONE_F - FRAC_W'(origin_y_i[FB-1:0]);
    end
    if (cmd_i.div_store && div_done) begin
      case (cmd_i.div_sel)
        DIV_STEP_X: stepx_q <= smallx ? DELTA_MAX : quotient[STEP_W-1:0];
        DIV_STEP_Y: stepy_q <= smally ? DELTA_MAX : quotient[STEP_W-1:0];
        DIV_DIST:   dist_q  <= dist_calc;
        default:    ;
      endcase
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.acc_op)
      ACC_SET_X: sidex_q <= SIDE_W'(prod_q);
      ACC_ADD_X: sidex_q <= sidex_q + SIDE_W'(prod_q >> FB);
      ACC_SET_Y: sidey_q <= SIDE_W'(prod_q);
      ACC_ADD_Y: sidey_q <= sidey_q + SIDE_W'(prod_q >> FB);
      default:   ;
    endcase
    if (cmd_i.step) begin
      cx_q   <= nx;
      cy_q   <= ny;
      vert_q <= lt;
      oob_q  <= oob_next;
      vld_q  <= valid_q[raddr];
      if (lt) begin
        sidex_q <= sidex_q + SIDE_W'(stepx_q);
      end else begin
        sidey_q <= sidey_q + SIDE_W'(stepy_q);
      end
    end
    if (cmd_i.wall_mul) begin
      wprod_q <= $signed({1'b0, dist_q}) * comp;
    end
    if (cmd_i.out_en) begin
      res_dist_q <= dist_q;
      res_wc_q   <= u_fin;
      res_cx_q   <= cx_q;
      res_cy_q   <= cy_q;
      res_vert_q <= vert_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.hit      = oob_q || (vld_q && ram_rd);
  assign status_o.limit    = cnt_q >= CNT_W'(WALK_LIMIT);

  assign result_valid_o    = res_valid_q;
  assign hit_distance_o    = res_dist_q;
  assign wall_coordinate_o = res_wc_q;
  assign hit_cell_x_o      = res_cx_q;
  assign hit_cell_y_o      = res_cy_q;
  assign vertical_side_o   = res_vert_q;

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe longer than one cycle");

  a_dist_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_dist_q >= DIST_W'(EPS))
    else $error("distance below epsilon");

  a_write_marks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_cell |=> valid_q[$past(waddr)])
    else $error("written cell not marked valid");

  a_step_adjacent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> ((cx_q != $past(cx_q)) != (cy_q != $past(cy_q))))
    else $error("walk step did not move exactly one axis");

endmodule

// File: rtl/grc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster controller
// Sequences map writes, divisions, side products, the cell walk and the result.
// ----------------------------------------------------------------------------
module grc_ctrl
  import grc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    operation_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (start && operation_i == OP_CAST) state_d = ST_DX_GO;
      ST_DX_GO:   state_d = ST_DX_WAIT;
      ST_DX_WAIT: if (status_i.div_done) state_d = ST_DY_GO;
      ST_DY_GO:   state_d = ST_DY_WAIT;
      ST_DY_WAIT: if (status_i.div_done) state_d = ST_MUL0;
      ST_MUL0:    state_d = ST_MUL1;
      ST_MUL1:    state_d = ST_MUL2;
      ST_MUL2:    state_d = ST_MUL3;
      ST_MUL3:    state_d = ST_MUL4;
      ST_MUL4:    state_d = ST_WALK;
      ST_WALK:    state_d = ST_PROBE;
      ST_PROBE:   state_d = (status_i.hit || status_i.limit) ? ST_DD_GO : ST_WALK;
      ST_DD_GO:   state_d = ST_DD_WAIT;
      ST_DD_WAIT: if (status_i.div_done) state_d = ST_WMUL;
      ST_WMUL:    state_d = ST_OUT;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_STEP_X;
    cmd_o.mul_sel = MUL_X_HI;
    cmd_o.acc_op  = ACC_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.wr_cell = start && operation_i == OP_WRITE;
        cmd_o.load    = start && operation_i == OP_CAST;
      end
      ST_DX_GO:   cmd_o.div_start = 1'b1;
      ST_DX_WAIT: cmd_o.div_store = 1'b1;
      ST_DY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_STEP_Y;
      end
      ST_DY_WAIT: begin
        cmd_o.div_store = 1'b1;
        cmd_o.div_sel   = DIV_STEP_Y;
      end
      ST_MUL0: cmd_o.mul_en = 1'b1;
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X_LO;
        cmd_o.acc_op  = ACC_SET_X;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y_HI;
        cmd_o.acc_op  = ACC_ADD_X;
      end
      ST_MUL3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y_LO;
        cmd_o.acc_op  = ACC_SET_Y;
      end
      ST_MUL4: cmd_o.acc_op = ACC_ADD_Y;
      ST_WALK: cmd_o.step = 1'b1;
      ST_DD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_DIST;
      end
      ST_DD_WAIT: begin
        cmd_o.div_store = 1'b1;
        cmd_o.div_sel   = DIV_DIST;
      end
      ST_WMUL: cmd_o.wall_mul = 1'b1;
      ST_OUT:  cmd_o.out_en   = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != ST_IDLE;

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DX_WAIT || state_q == ST_DY_WAIT ||
                           state_q == ST_DD_WAIT))
    else $error("divider finished outside a wait state");

endmodule

// File: rtl/grid_ray_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster
// A write transaction leaves the controller idle; busy stays low.
// A cast holds busy high until its result is strobed, for a walk of up to 34 cells;
// the next item can be taken in the cycle that the result is strobed.
// Three serial divisions (start, 40 quotient bits, done), multiply states MUL0 to MUL4,
// a WALK and a PROBE state per cell for the map RAM read, a wall product and output.
// Reset clears the strobe and every map cell reads empty through per-cell valid
// flops; the result strobe lasts one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
module grid_ray_caster
  import grc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation_i,
  input  logic [IDX_W-1:0]         cell_x_i,
  input  logic [IDX_W-1:0]         cell_y_i,
  input  logic                     cell_is_wall_i,
  input  logic [ORG_W-1:0]         origin_x_i,
  input  logic [ORG_W-1:0]         origin_y_i,
  input  logic signed [DIR_W-1:0]  direction_x_i,
  input  logic signed [DIR_W-1:0]  direction_y_i,
  output logic                     result_valid_o,
  output logic [DIST_W-1:0]        hit_distance_o,
  output logic [WC_W-1:0]          wall_coordinate_o,
  output logic signed [CELL_W-1:0] hit_cell_x_o,
  output logic signed [CELL_W-1:0] hit_cell_y_o,
  output logic                     vertical_side_o
);

  cmd_t    cmd;
  status_t status;
  logic    go;

  assign go = start && !busy;

  grc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (go),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  grc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cell_x_i          (cell_x_i),
    .cell_y_i          (cell_y_i),
    .cell_is_wall_i    (cell_is_wall_i),
    .origin_x_i        (origin_x_i),
    .origin_y_i        (origin_y_i),
    .direction_x_i     (direction_x_i),
    .direction_y_i     (direction_y_i),
    .result_valid_o    (result_valid_o),
    .hit_distance_o    (hit_distance_o),
    .wall_coordinate_o (wall_coordinate_o),
    .hit_cell_x_o      (hit_cell_x_o),
    .hit_cell_y_o      (hit_cell_y_o),
    .vertical_side_o   (vertical_side_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster testbench
// Loads wall maps and casts rays, directed corner cases first, then random
// traffic with varying sender gaps. A built-in predictor walks each ray over
// its own copy of the map; every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import grc_pkg::*;

  localparam int WD_LIMIT  = 4000;
  localparam int DRAIN_GAP = 300;

  typedef struct {
    logic [DIST_W-1:0] hdist;
    logic [WC_W-1:0]   wcoord;
    logic [CELL_W-1:0] hx;
    logic [CELL_W-1:0] hy;
    logic              vert;
  } hit_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     operation_i = 1'b0;
  logic [IDX_W-1:0]         cell_x_i = '0;
  logic [IDX_W-1:0]         cell_y_i = '0;
  logic                     cell_is_wall_i = 1'b0;
  logic [ORG_W-1:0]         origin_x_i = '0;
  logic [ORG_W-1:0]         origin_y_i = '0;
  logic signed [DIR_W-1:0]  direction_x_i = '0;
  logic signed [DIR_W-1:0]  direction_y_i = '0;
  logic                     result_valid_o;
  logic [DIST_W-1:0]        hit_distance_o;
  logic [WC_W-1:0]          wall_coordinate_o;
  logic signed [CELL_W-1:0] hit_cell_x_o;
  logic signed [CELL_W-1:0] hit_cell_y_o;
  logic                     vertical_side_o;

  bit   wall_copy [MAP_H][MAP_W];
  hit_t pending_hits[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   accepted_now;

  grid_ray_caster i_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Walk the ray over the map copy, as the block is meant to.
  function automatic hit_t predict_cast(logic [ORG_W-1:0] ox_i, logic [ORG_W-1:0] oy_i,
                                        logic signed [DIR_W-1:0] dx_i,
                                        logic signed [DIR_W-1:0] dy_i);
    longint one, mask, dmax, ox, oy, dx, dy, magx, magy, stx, sty, sdx, sdy;
    longint cx, cy, sx, sy, num, dv, mnum, mdiv, q, dist_v, comp, org_o, pos, u;
    bit     vert, flip, wall;
    hit_t   h;
    one  = longint'(1) << FB;
    mask = one - 1;
    dmax = longint'(1) << (2 * FB);
    ox = ox_i; oy = oy_i; dx = dx_i; dy = dy_i;
    magx = dx < 0 ? -dx : dx;
    magy = dy < 0 ? -dy : dy;
    stx = magx < EPS ? dmax : dmax / magx;
    sty = magy < EPS ? dmax : dmax / magy;
    cx = ox >> FB;
    cy = oy >> FB;
    sx = dx < 0 ? -1 : 1;
    sy = dy < 0 ? -1 : 1;
    u   = dx < 0 ? (ox & mask) : one - (ox & mask);
    sdx = u * (stx >> FB) + ((u * (stx & mask)) >> FB);
    u   = dy < 0 ? (oy & mask) : one - (oy & mask);
    sdy = u * (sty >> FB) + ((u * (sty & mask)) >> FB);
    vert = 1'b0;
    for (int i = 0; i < WALK_LIMIT; i++) begin
      if (sdx < sdy) begin
        sdx += stx; cx += sx; vert = 1'b1;
      end else begin
        sdy += sty; cy += sy; vert = 1'b0;
      end
      wall = (cx < 0 || cx >= MAP_W || cy < 0 || cy >= MAP_H) ? 1'b1 : wall_copy[cy][cx];
      if (wall) break;
    end
    if (vert) begin
      num = cx * one - ox + (sx < 0 ? one : 0);
      dv  = magx < EPS ? EPS : dx;
    end else begin
      num = cy * one - oy + (sy < 0 ? one : 0);
      dv  = magy < EPS ? EPS : dy;
    end
    mnum = num < 0 ? -num : num;
    mdiv = dv < 0 ? -dv : dv;
    q = (mnum << FB) / mdiv;
    if (((num < 0) != (dv < 0)) && q != 0) dist_v = EPS;
    else dist_v = q < EPS ? EPS : q;
    if (dist_v > longint'(DIST_TOP)) dist_v = DIST_TOP;
    if (vert) begin
      comp = dy; org_o = oy; flip = dx > 0;
    end else begin
      comp = dx; org_o = ox; flip = dy < 0;
    end
    pos = org_o * one + dist_v * comp;
    u = (pos & (dmax - 1)) >> FB;
    if (flip) begin
      u = one - u;
      if (u > mask) u = mask;
    end
    h.hdist  = dist_v[DIST_W-1:0];
    h.wcoord = u[WC_W-1:0];
    h.hx     = cx[CELL_W-1:0];
    h.hy     = cy[CELL_W-1:0];
    h.vert   = vert;
    return h;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // One transaction; returns just after the accepting edge, start still high.
  task automatic send_item(bit op, logic [IDX_W-1:0] x, logic [IDX_W-1:0] y, bit wl,
                           logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy,
                           logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy);
    start          <= 1'b1;
    operation_i    <= op;
    cell_x_i       <= x;
    cell_y_i       <= y;
    cell_is_wall_i <= wl;
    origin_x_i     <= ox;
    origin_y_i     <= oy;
    direction_x_i  <= dx;
    direction_y_i  <= dy;
    do @(posedge clk_i); while (busy);
    if (op == OP_WRITE) wall_copy[y][x] = wl;
    else pending_hits.push_back(predict_cast(ox, oy, dx, dy));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic write_cell(int x, int y, bit wl);
    send_item(OP_WRITE, IDX_W'(x), IDX_W'(y), wl, '0, '0, '0, '0);
  endtask

  task automatic cast_ray(logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy,
                          logic signed [DIR_W-1:0] dx, logic signed [DIR_W-1:0] dy);
    send_item(OP_CAST, '0, '0, 1'b0, ox, oy, dx, dy);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  // Empty map, rays to the border; extremes of origin and direction; then rays against written walls.
  task automatic test_map_edges();
    cast_ray('0, '0, 18'sh1ffff, 18'sh1ffff);
    cast_ray(20'hfffff, 20'hfffff, -18'sh20000, -18'sh20000);
    cast_ray(20'hfffff, '0, 18'sh1ffff, 18'sh0);
    cast_ray('0, 20'hfffff, -18'sh20000, 18'sh1ffff);
    cast_ray(20'h80000, 20'h80000, 18'sh0, 18'sh0);       // zero direction
    write_cell(0, 0, 1'b1);
    write_cell(15, 15, 1'b1);
    write_cell(7, 8, 1'b1);
    cast_ray(20'h88000, 20'h88000, -18'sh10000, -18'sh10000);
    cast_ray(20'h08000, 20'h08000, 18'sh10000, 18'sh0);   // origin inside a wall
    write_cell(15, 15, 1'b0);
    write_cell(0, 0, 1'b0);
  endtask

  // Tiny components, axis-aligned, flip of a zero coordinate.
  task automatic test_special_directions();
    cast_ray(20'h48000, 20'h58000, 18'sh3, 18'sh10000);
    cast_ray(20'h48000, 20'h58000, -18'sh6, -18'sh10000);
    cast_ray(20'h48000, 20'h58000, 18'sh10000, -18'sh1);
    cast_ray(20'h40000, 20'h50000, 18'sh10000, 18'sh10000);
    cast_ray(20'h40000, 20'h50000, -18'sh10000, -18'sh10000);
    cast_ray(20'h70000, 20'h70000, 18'sh7, -18'sh7);
    cast_ray(20'h70000, 20'h70000, 18'sh1, 18'sh1);
    write_cell(8, 7, 1'b1);
    cast_ray(20'h7ffff, 20'h78000, 18'sh10000, 18'sh0);   // wall right next door
    write_cell(8, 7, 1'b0);
  endtask

  function automatic logic signed [DIR_W-1:0] rand_direction();
    case ($urandom_range(0, 5))
      0:       return DIR_W'($urandom_range(0, 16) - 8);
      1:       return $urandom_range(0, 1) ? 18'sh1ffff : -18'sh20000;
      default: return DIR_W'($urandom());
    endcase
  endfunction

  task automatic test_random_traffic(int items, int idle_pct);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 35)
        write_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 99) < 30);
      else
        cast_ray(ORG_W'($urandom()), ORG_W'($urandom()), rand_direction(), rand_direction());
      if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 8));
    end
  endtask

  // Results: the block cannot be held off, so check every strobe.
  always @(posedge clk_i) begin
    hit_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_hits.pop_front();
        if (hit_distance_o !== w.hdist)
          report_mismatch("hit_distance", hit_distance_o, w.hdist);
        if (wall_coordinate_o !== w.wcoord)
          report_mismatch("wall_coordinate", wall_coordinate_o, w.wcoord);
        if (hit_cell_x_o !== w.hx) report_mismatch("hit_cell_x", hit_cell_x_o, w.hx);
        if (hit_cell_y_o !== w.hy) report_mismatch("hit_cell_y", hit_cell_y_o, w.hy);
        if (vertical_side_o !== w.vert)
          report_mismatch("vertical_side", vertical_side_o, w.vert);
      end
    end
  end

  // Watchdog: cycles with neither an input nor a result transaction.
  always @(posedge clk_i) begin
    accepted_now = (start && !busy) || result_valid_o;
    idle_cycles  = accepted_now ? 0 : idle_cycles + 1;
    if (rst_ni && idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_map_edges();
    test_special_directions();
    test_random_traffic(220, 0);
    test_random_traffic(220, 60);
    wait_results_drained();
    test_random_traffic(220, 13);
    test_random_traffic(220, 0);
    test_random_traffic(200, 60);
    wait_results_drained();
    repeat (DRAIN_GAP) @(posedge clk_i);
    if (fail_count == 0 && pending_hits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
